[rtl/mpfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants and types for the monochrome page framebuffer scaler.
// ----------------------------------------------------------------------------
package mpfb_pkg;

   localparam int SRC_WIDTH   = 128;
   localparam int SRC_PAGES   = 8;
   localparam int STORE_BYTES = SRC_WIDTH * SRC_PAGES;
   localparam int DEST_ROWS   = SRC_PAGES * 16;

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int COL_W  = $clog2(SRC_WIDTH);
   localparam int ROW_W  = $clog2(DEST_ROWS);
   localparam int PAGE_W = ROW_W - 4;
   localparam int BIT_W  = 3;

   localparam int FB_ADDR_W  = 10;
   localparam int FB_DATA_W  = 8;
   localparam int COLOR_W    = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;
   localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG_COLOR = 1'b0,
      CSR_BG_COLOR = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_PULL = 1'b1
   } action_type;

   // current stream position as seen by the read side
   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic [BIT_W-1:0]  bit_sel;
      logic              low_byte;
      logic              row_end;
      logic              frame_end;
      logic              at_start;
   } pos_type;

endpackage

[rtl/mpfb_channels.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb channels
// Valid/ready channels for request items and stream byte responses.
// ----------------------------------------------------------------------------
interface mpfb_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [9:0] fb_address;
   logic [7:0] fb_data;

   modport source (output valid, output action, output fb_address, output fb_data,
                   input ready);
   modport sink (input valid, input action, input fb_address, input fb_data,
                 output ready);
endinterface

interface mpfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       last_of_row;
   logic       last_of_frame;

   modport source (output valid, output pixel_byte, output last_of_row,
                   output last_of_frame, input ready);
   modport sink (input valid, input pixel_byte, input last_of_row,
                 input last_of_frame, output ready);
endinterface

[rtl/mono_page_fb_to_rgb565_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_fb_to_rgb565_scaler
// Page-layout monochrome framebuffer streamed out as 2x scaled RGB565 bytes.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer
// req_bus   in   load byte (action 0) or pull next stream byte (action 1)
// rsp_bus   out  one stream byte per pull, row and frame end flags
// csr_*     in   fg_color / bg_color write, no read-back
//
// One item per cycle sustained while the output is not stalled; a pull's
// transfer reads the framebuffer RAM into the read register, then color
// select loads the output register.
// Reset zeroes the position counters and restores the default colors;
// RAM contents are undefined.
// A stalled output holds the pipeline; loads and pulls wait together.
// ----------------------------------------------------------------------------
module mono_page_fb_to_rgb565_scaler (
   input  logic                               clock,
   input  logic                               reset,
   mpfb_req_if.sink                           req_bus,
   mpfb_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [mpfb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mpfb_pkg::COLOR_W-1:0]       csr_wdata
);
   import mpfb_pkg::*;

   logic [FB_DATA_W-1:0] frame_mem [STORE_BYTES];

   logic [COLOR_W-1:0] fg_ff, bg_ff;

   pos_type pos;
   logic    req_xfer, pull_xfer, load_xfer;
   logic    s1_move;

   logic                 s1_valid_ff, s1_valid_in;
   logic [BIT_W-1:0]     s1_bit_ff;
   logic                 s1_low_ff, s1_row_end_ff, s1_frame_end_ff;
   logic [FB_DATA_W-1:0] rd_data_ff;

   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff;
   logic                 out_row_ff, out_frame_ff;
   logic [COLOR_W-1:0]   color;

   assign s1_move   = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_move;
   assign req_xfer  = req_bus.valid && req_bus.ready;
   assign pull_xfer = req_xfer && (req_bus.action == ACT_PULL);
   assign load_xfer = req_xfer && (req_bus.action == ACT_LOAD);

   mpfb_position u_position (
      .clock   (clock),
      .reset   (reset),
      .advance (pull_xfer),
      .pos     (pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_ff <= csr_wdata;
            CSR_BG_COLOR: bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // framebuffer RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_xfer && (32'(req_bus.fb_address) < STORE_BYTES)) begin
         frame_mem[req_bus.fb_address[ADDR_W-1:0]] <= req_bus.fb_data;
      end
      if (pull_xfer) begin
         rd_data_ff <= frame_mem[pos.rd_addr];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_bus.ready) begin
         s1_valid_in = pull_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (pull_xfer) begin
         s1_bit_ff       <= pos.bit_sel;
         s1_low_ff       <= pos.low_byte;
         s1_row_end_ff   <= pos.row_end;
         s1_frame_end_ff <= pos.frame_end;
      end
   end

   assign color = rd_data_ff[s1_bit_ff] ? fg_ff : bg_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_valid_ff) begin
         out_byte_ff  <= s1_low_ff ? color[7:0] : color[15:8];
         out_row_ff   <= s1_row_end_ff;
         out_frame_ff <= s1_frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.pixel_byte    = out_byte_ff;
   assign rsp_bus.last_of_row   = out_row_ff;
   assign rsp_bus.last_of_frame = out_frame_ff;

   a_frame_implies_row: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_frame_ff |-> out_row_ff)
      else $error("last_of_frame without last_of_row");

   a_pull_fills_s1: assert property (@(posedge clock) disable iff (reset)
      pull_xfer |=> s1_valid_ff)
      else $error("accepted pull did not reach read stage");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request accepted while pipeline is full");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      pull_xfer && pos.frame_end |=> pos.at_start)
      else $error("position did not wrap after frame end");

endmodule

[rtl/mpfb_position.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfb_position
// Destination row, source column and byte phase counters with wrap.
// ----------------------------------------------------------------------------
module mpfb_position (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   output mpfb_pkg::pos_type pos
);
   import mpfb_pkg::*;

   logic [1:0]       phase_ff, phase_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [ROW_W-2:0]  src_row;
   logic [PAGE_W-1:0] page;
   logic              col_last, row_last;

   assign src_row  = row_ff[ROW_W-1:1];
   assign page     = src_row[ROW_W-2:BIT_W];
   assign col_last = (col_ff == COL_W'(SRC_WIDTH - 1));
   assign row_last = (row_ff == ROW_W'(DEST_ROWS - 1));

   always_comb begin
      pos.rd_addr   = ADDR_W'(ADDR_W'(page) * ADDR_W'(SRC_WIDTH) + ADDR_W'(col_ff));
      pos.bit_sel   = src_row[BIT_W-1:0];
      pos.low_byte  = phase_ff[0];
      pos.row_end   = (phase_ff == 2'd3) && col_last;
      pos.frame_end = pos.row_end && row_last;
      pos.at_start  = (phase_ff == 2'd0) && (col_ff == '0) && (row_ff == '0);
   end

   always_comb begin
      phase_in = phase_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (advance) begin
         phase_in = phase_ff + 2'd1;
         if (phase_ff == 2'd3) begin
            col_in = col_last ? '0 : col_ff + COL_W'(1);
            if (col_last) begin
               row_in = row_last ? '0 : row_ff + ROW_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

endmodule
